### rtl/fdaf_pkg.sv
package fdaf_pkg;

	localparam int MAX_FRAMES_DEF = 64;
	localparam int WORD_W = 32;
	localparam int POS_W = 6;

	// floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for x below 2**18
	localparam int RECIP_W = 16;
	localparam logic [RECIP_W-1:0] RECIP_10 = 16'd52429;
	localparam int RECIP_SHIFT = 19;

	localparam int DIV_STEP_W = 5;
	localparam logic [DIV_STEP_W-1:0] DIV_STEP_LAST = 5'd31;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_MUL,
		B_TOT,
		B_RD,
		B_LD
	} back_state_t;

	function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

### rtl/fdaf_in_if.sv
interface fdaf_in_if;
	logic valid;
	logic ready;
	logic [fdaf_pkg::WORD_W-1:0] duration_word;
	logic last_item;

	modport source(output valid, output duration_word, output last_item, input ready);
	modport sink(input valid, input duration_word, input last_item, output ready);
endinterface

### rtl/fdaf_out_if.sv
interface fdaf_out_if;
	logic valid;
	logic ready;
	logic [fdaf_pkg::POS_W-1:0] position;
	logic [fdaf_pkg::WORD_W-1:0] fixed_word;
	logic [fdaf_pkg::WORD_W-1:0] batch_total;
	logic was_corrected;
	logic overflowed;
	logic final_result;

	modport source(output valid, output position, output fixed_word, output batch_total,
		output was_corrected, output overflowed, output final_result, input ready);
	modport sink(input valid, input position, input fixed_word, input batch_total,
		input was_corrected, input overflowed, input final_result, output ready);
endinterface

### rtl/fdaf_ram.sv
module fdaf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/fdaf_queue.sv
module fdaf_queue #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_data,
	output logic  full,
	input  logic  pop,
	output item_t head,
	output logic  head_valid
);

	item_t slot_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] fill_q;

	assign full = fill_q == 2'd2;
	assign head_valid = fill_q != 2'd0;
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### rtl/fdaf_front.sv
module fdaf_front #(
	parameter int MAX_FRAMES = fdaf_pkg::MAX_FRAMES_DEF,
	parameter type batch_t = logic,
	localparam int IW = $clog2(MAX_FRAMES),
	localparam int CW = $clog2(MAX_FRAMES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fdaf_in_if.sink                     durations,
	output logic                        word_we,
	output logic [IW:0]                 word_addr,
	output logic [fdaf_pkg::WORD_W-1:0] word_data,
	output logic                        mark_we,
	output logic [IW:0]                 mark_addr,
	output logic                        mark_data,
	output logic                        push,
	output batch_t                      push_data,
	input  logic                        full
);

	logic [CW-1:0] count_q;
	logic [CW-1:0] steady_q;
	logic [fdaf_pkg::WORD_W-1:0] sum_q;
	logic [fdaf_pkg::WORD_W-1:0] prev_q;
	logic ovf_q;
	logic bank_q;

	logic accept;
	logic stored;
	logic same;
	logic add;
	logic [CW-1:0] count_m1;
	logic [CW-1:0] count_nx;
	logic [CW-1:0] steady_nx;
	logic [fdaf_pkg::WORD_W-1:0] sum_nx;
	logic [fdaf_pkg::WORD_W-1:0] tail_word;

	assign durations.ready = !full;
	assign accept = durations.valid && !full;
	assign stored = count_q < CW'(MAX_FRAMES);
	assign same = prev_q == durations.duration_word;
	assign add = stored && (count_q != '0) && same;
	assign count_m1 = count_q - CW'(1);

	assign count_nx = stored ? count_q + CW'(1) : count_q;
	assign steady_nx = add ? steady_q + CW'(1) : steady_q;
	assign sum_nx = add ? sum_q + fdaf_pkg::swap_bytes(prev_q) : sum_q;
	assign tail_word = stored ? durations.duration_word : prev_q;

	assign word_we = accept && stored;
	assign word_addr = {bank_q, count_q[IW-1:0]};
	assign word_data = durations.duration_word;
	assign mark_we = accept && stored && (count_q != '0);
	assign mark_addr = {bank_q, count_m1[IW-1:0]};
	assign mark_data = !same;

	assign push = accept && durations.last_item;

	always_comb begin
		push_data.bank = bank_q;
		push_data.n = count_nx;
		push_data.steady = steady_nx;
		push_data.sum = sum_nx;
		push_data.tail = fdaf_pkg::swap_bytes(tail_word);
		push_data.ovf = ovf_q || !stored;
	end

	always_ff @(posedge clk) begin
		if (accept && stored) begin
			prev_q <= durations.duration_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			steady_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (durations.last_item) begin
				count_q <= '0;
				steady_q <= '0;
				sum_q <= '0;
				ovf_q <= 1'b0;
				bank_q <= !bank_q;
			end else begin
				count_q <= count_nx;
				steady_q <= steady_nx;
				sum_q <= sum_nx;
				ovf_q <= ovf_q || !stored;
			end
		end
	end

endmodule

### rtl/fdaf_back.sv
module fdaf_back #(
	parameter int MAX_FRAMES = fdaf_pkg::MAX_FRAMES_DEF,
	parameter type batch_t = logic,
	localparam int IW = $clog2(MAX_FRAMES),
	localparam int CW = $clog2(MAX_FRAMES + 1),
	localparam int TW = CW + 2 + fdaf_pkg::RECIP_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  batch_t                      head,
	input  logic                        head_valid,
	output logic                        pop,
	output logic                        rd_en,
	output logic [IW:0]                 rd_addr,
	input  logic [fdaf_pkg::WORD_W-1:0] word_rd,
	input  logic                        mark_rd,
	fdaf_out_if.source                  results
);

	fdaf_pkg::back_state_t state_q, state_nx;

	logic [fdaf_pkg::WORD_W-1:0] quo_q;
	logic [CW-1:0] rem_q;
	logic [fdaf_pkg::DIV_STEP_W-1:0] step_q;
	logic [fdaf_pkg::WORD_W-1:0] prod_q;
	logic [TW-1:0] thr_prod_q;
	logic [fdaf_pkg::WORD_W-1:0] total_q;
	logic corr_q;
	logic [IW-1:0] idx_q;

	logic out_valid_q;
	logic [fdaf_pkg::POS_W-1:0] pos_q;
	logic [fdaf_pkg::WORD_W-1:0] fixed_q;
	logic [fdaf_pkg::WORD_W-1:0] btotal_q;
	logic bcorr_q;
	logic bovf_q;
	logic bfinal_q;

	logic [CW:0] rem_sh;
	logic rem_ge;
	logic [CW-1:0] rem_nx;
	logic [CW-1:0] anom;
	logic [CW+fdaf_pkg::WORD_W-1:0] mul_full;
	logic [CW+1:0] tri_n;
	logic [CW-1:0] thr_raw;
	logic [CW-1:0] thr;
	logic corr_nx;
	logic is_last;
	logic slot_free;
	logic load_out;
	logic [fdaf_pkg::WORD_W-1:0] avg_word;

	assign rem_sh = {rem_q, quo_q[fdaf_pkg::WORD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, head.steady};
	assign rem_nx = rem_ge ? CW'(rem_sh - {1'b0, head.steady}) : CW'(rem_sh);

	assign anom = head.n - CW'(1) - head.steady;
	assign mul_full = (CW + fdaf_pkg::WORD_W)'(anom) * (CW + fdaf_pkg::WORD_W)'(quo_q);
	assign tri_n = {1'b0, head.n, 1'b0} + {2'b00, head.n};

	assign thr_raw = CW'(thr_prod_q >> fdaf_pkg::RECIP_SHIFT);
	assign thr = (thr_raw == '0) ? CW'(1) : thr_raw;
	assign corr_nx = (head.steady != '0) &&
		(({1'b0, head.steady} + {1'b0, thr}) > {1'b0, head.n});

	assign avg_word = fdaf_pkg::swap_bytes(quo_q);
	assign is_last = CW'(idx_q) == (head.n - CW'(1));
	assign slot_free = !out_valid_q || results.ready;

	assign rd_addr = {head.bank, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdaf_pkg::B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		pop = 1'b0;
		rd_en = 1'b0;
		load_out = 1'b0;
		case (state_q)
			fdaf_pkg::B_IDLE: begin
				if (head_valid) begin
					state_nx = fdaf_pkg::B_DIV;
				end
			end
			fdaf_pkg::B_DIV: begin
				if (step_q == fdaf_pkg::DIV_STEP_LAST) begin
					state_nx = fdaf_pkg::B_MUL;
				end
			end
			fdaf_pkg::B_MUL: begin
				state_nx = fdaf_pkg::B_TOT;
			end
			fdaf_pkg::B_TOT: begin
				state_nx = fdaf_pkg::B_RD;
			end
			fdaf_pkg::B_RD: begin
				rd_en = 1'b1;
				state_nx = fdaf_pkg::B_LD;
			end
			fdaf_pkg::B_LD: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (is_last) begin
						pop = 1'b1;
						state_nx = fdaf_pkg::B_IDLE;
					end else begin
						state_nx = fdaf_pkg::B_RD;
					end
				end
			end
			default: begin
				state_nx = fdaf_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fdaf_pkg::B_IDLE: begin
				quo_q <= head.sum;
				rem_q <= '0;
				step_q <= '0;
			end
			fdaf_pkg::B_DIV: begin
				quo_q <= {quo_q[fdaf_pkg::WORD_W-2:0], rem_ge};
				rem_q <= rem_nx;
				step_q <= step_q + fdaf_pkg::DIV_STEP_W'(1);
			end
			fdaf_pkg::B_MUL: begin
				prod_q <= mul_full[fdaf_pkg::WORD_W-1:0];
				thr_prod_q <= TW'(tri_n) * TW'(fdaf_pkg::RECIP_10);
			end
			fdaf_pkg::B_TOT: begin
				total_q <= head.sum + head.tail + prod_q;
				corr_q <= corr_nx;
				idx_q <= '0;
			end
			fdaf_pkg::B_LD: begin
				if (load_out && !is_last) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			pos_q <= fdaf_pkg::POS_W'(idx_q);
			fixed_q <= (corr_q && mark_rd && !is_last) ? avg_word : word_rd;
			btotal_q <= corr_q ? total_q : '0;
			bcorr_q <= corr_q;
			bovf_q <= head.ovf;
			bfinal_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid = out_valid_q;
	assign results.position = pos_q;
	assign results.fixed_word = fixed_q;
	assign results.batch_total = btotal_q;
	assign results.was_corrected = bcorr_q;
	assign results.overflowed = bovf_q;
	assign results.final_result = bfinal_q;

endmodule

### rtl/frame_duration_anomaly_fix.sv
// loading: one item per cycle while the batch queue is not full, no result until the item marked last
// after the last item: averaging (32-step divider, multiply, total),
// then one result per registered store read, held back while the output is not taken
// two store banks and a two-batch queue let the next batch load during emission
// reset clears all control state; store and marks are undefined until written
module frame_duration_anomaly_fix #(
	parameter int MAX_FRAMES = fdaf_pkg::MAX_FRAMES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	fdaf_in_if.sink      durations,
	fdaf_out_if.source   results
);

	localparam int IW = $clog2(MAX_FRAMES);
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int DEPTH = 2 << IW;

	typedef struct packed {
		logic bank;
		logic [CW-1:0] n;
		logic [CW-1:0] steady;
		logic [fdaf_pkg::WORD_W-1:0] sum;
		logic [fdaf_pkg::WORD_W-1:0] tail;
		logic ovf;
	} batch_t;

	logic word_we;
	logic [IW:0] word_addr;
	logic [fdaf_pkg::WORD_W-1:0] word_data;
	logic mark_we;
	logic [IW:0] mark_addr;
	logic mark_data;
	logic q_push;
	batch_t q_push_data;
	logic q_full;
	logic q_pop;
	batch_t q_head;
	logic q_head_valid;
	logic rd_en;
	logic [IW:0] rd_addr;
	logic [fdaf_pkg::WORD_W-1:0] word_rd;
	logic mark_rd;

	fdaf_front #(.MAX_FRAMES(MAX_FRAMES), .batch_t(batch_t)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.durations(durations),
		.word_we(word_we),
		.word_addr(word_addr),
		.word_data(word_data),
		.mark_we(mark_we),
		.mark_addr(mark_addr),
		.mark_data(mark_data),
		.push(q_push),
		.push_data(q_push_data),
		.full(q_full)
	);

	fdaf_queue #(.item_t(batch_t)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_push_data),
		.full(q_full),
		.pop(q_pop),
		.head(q_head),
		.head_valid(q_head_valid)
	);

	fdaf_ram #(.WIDTH(fdaf_pkg::WORD_W), .DEPTH(DEPTH)) u_word_ram (
		.clk(clk),
		.we(word_we),
		.waddr(word_addr),
		.wdata(word_data),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(word_rd)
	);

	fdaf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mark_ram (
		.clk(clk),
		.we(mark_we),
		.waddr(mark_addr),
		.wdata(mark_data),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(mark_rd)
	);

	fdaf_back #(.MAX_FRAMES(MAX_FRAMES), .batch_t(batch_t)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(q_head),
		.head_valid(q_head_valid),
		.pop(q_pop),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.word_rd(word_rd),
		.mark_rd(mark_rd),
		.results(results)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("batch pushed into full queue");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !durations.ready)
		else $error("items taken while both banks are held");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("pop from empty queue");

	a_store_write_only_when_taken: assert property (@(posedge clk) disable iff (!arst_n)
		word_we |-> (durations.valid && durations.ready))
		else $error("store written without an item");

endmodule
